/* rtl/sqt_pkg.sv */
package sqt_pkg;

  // Byte codes the tokenizer looks for.
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_E2    = 8'hE2;
  localparam logic [7:0] CH_80    = 8'h80;
  localparam logic [7:0] CH_9C    = 8'h9C;
  localparam logic [7:0] CH_9D    = 8'h9D;

  // Result item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Curly-quote prefix hold codes.
  localparam logic [1:0] PFX_NONE  = 2'd0;
  localparam logic [1:0] PFX_E2    = 2'd1;
  localparam logic [1:0] PFX_E2_80 = 2'd2;

  // One input item causes at most this many results.
  localparam int MAX_RES   = 4;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W = $clog2(MAX_RES);

  // Result queue sizing.
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic       in_term;
    logic       dash_pending;
    logic       quoted_phrase;
    logic       negated_flag;
    logic       term_has_bytes;
    logic [1:0] curly_prefix_count;
    logic       highlight_taken;
    logic       current_is_highlight;
  } state_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] term_byte;
    logic       term_negated;
    logic       first_of_term;
    logic       highlight_term;
    logic       last_of_run;
  } res_t;

  // Results produced by one input item, in order, plus how many are valid.
  typedef struct packed {
    logic [RES_CNT_W-1:0] cnt;
    res_t [MAX_RES-1:0]   items;
  } push_t;

endpackage

/* rtl/sqt_core.sv */
module sqt_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          byte_value,
  input  logic                end_of_query,
  output sqt_pkg::push_t      push
);

  typedef struct packed {
    sqt_pkg::state_t st;
    sqt_pkg::push_t  res;
  } work_t;

  sqt_pkg::state_t state_r;
  sqt_pkg::state_t state_nxt;

  function automatic logic is_space(input logic [7:0] b);
    return (b == sqt_pkg::CH_SPACE) || (b >= sqt_pkg::CH_TAB && b <= sqt_pkg::CH_CR);
  endfunction

  function automatic work_t put_item(input work_t w, input logic kind,
                                     input logic [7:0] b, input logic first);
    work_t         o;
    sqt_pkg::res_t it;
    o = w;
    it.item_kind      = kind;
    it.term_byte      = b;
    it.term_negated   = w.st.negated_flag;
    it.first_of_term  = first;
    it.highlight_term = w.st.current_is_highlight;
    it.last_of_run    = 1'b0;
    if (w.res.cnt < sqt_pkg::RES_CNT_W'(sqt_pkg::MAX_RES)) begin
      o.res.items[w.res.cnt[sqt_pkg::RES_IDX_W-1:0]] = it;
      o.res.cnt = w.res.cnt + 1'b1;
    end
    return o;
  endfunction

  function automatic work_t emit_byte(input work_t w, input logic [7:0] b);
    work_t o;
    logic  first;
    o = w;
    first = 1'b0;
    if (!o.st.term_has_bytes) begin
      first = 1'b1;
      o.st.term_has_bytes = 1'b1;
      if (!o.st.negated_flag && !o.st.highlight_taken) begin
        o.st.current_is_highlight = 1'b1;
        o.st.highlight_taken      = 1'b1;
      end
    end
    return put_item(o, sqt_pkg::KIND_BYTE, b, first);
  endfunction

  function automatic work_t release_prefix(input work_t w);
    work_t o;
    o = w;
    if (w.st.curly_prefix_count != sqt_pkg::PFX_NONE) begin
      o = emit_byte(o, sqt_pkg::CH_E2);
    end
    if (w.st.curly_prefix_count >= sqt_pkg::PFX_E2_80) begin
      o = emit_byte(o, sqt_pkg::CH_80);
    end
    o.st.curly_prefix_count = sqt_pkg::PFX_NONE;
    return o;
  endfunction

  function automatic work_t finish_term(input work_t w);
    work_t o;
    o = release_prefix(w);
    if (o.st.term_has_bytes) begin
      o = put_item(o, sqt_pkg::KIND_END, 8'h00, 1'b0);
    end
    o.st.in_term              = 1'b0;
    o.st.quoted_phrase        = 1'b0;
    o.st.negated_flag         = 1'b0;
    o.st.term_has_bytes       = 1'b0;
    o.st.current_is_highlight = 1'b0;
    return o;
  endfunction

  work_t w;
  logic  do_term;
  logic  do_plain;
  logic  do_release;
  logic [sqt_pkg::RES_IDX_W-1:0] last_idx;

  always_comb begin
    w          = '0;
    w.st       = state_r;
    do_term    = 1'b0;
    do_plain   = 1'b1;
    do_release = 1'b0;
    last_idx   = '0;

    if (w.st.in_term) begin
      do_term = 1'b1;
    end else if (w.st.dash_pending) begin
      w.st.dash_pending = 1'b0;
      if (is_space(byte_value)) begin
        // A lone dash before whitespace is a one-byte positive term.
        w.st.in_term = 1'b1;
        w = emit_byte(w, sqt_pkg::CH_DASH);
        w = finish_term(w);
      end else begin
        w.st.negated_flag = 1'b1;
        w.st.in_term      = 1'b1;
        do_term           = 1'b1;
      end
    end else if (!is_space(byte_value)) begin
      if (byte_value == sqt_pkg::CH_DASH && !end_of_query) begin
        w.st.dash_pending = 1'b1;
      end else begin
        w.st.in_term = 1'b1;
        do_term      = 1'b1;
      end
    end

    if (do_term) begin
      if (w.st.curly_prefix_count == sqt_pkg::PFX_E2) begin
        if (byte_value == sqt_pkg::CH_80) begin
          w.st.curly_prefix_count = sqt_pkg::PFX_E2_80;
          do_plain = 1'b0;
        end else begin
          do_release = 1'b1;
        end
      end else if (w.st.curly_prefix_count >= sqt_pkg::PFX_E2_80) begin
        if (byte_value == sqt_pkg::CH_9C || byte_value == sqt_pkg::CH_9D) begin
          w.st.curly_prefix_count = sqt_pkg::PFX_NONE;
          w.st.quoted_phrase      = !w.st.quoted_phrase;
          do_plain = 1'b0;
        end else begin
          do_release = 1'b1;
        end
      end
      if (do_release) begin
        w = release_prefix(w);
      end
      if (do_plain) begin
        if (byte_value == sqt_pkg::CH_E2) begin
          w.st.curly_prefix_count = sqt_pkg::PFX_E2;
        end else if (byte_value == sqt_pkg::CH_QUOTE) begin
          w.st.quoted_phrase = !w.st.quoted_phrase;
        end else if (!w.st.quoted_phrase && is_space(byte_value)) begin
          w = finish_term(w);
        end else begin
          w = emit_byte(w, byte_value);
        end
      end
    end

    if (end_of_query) begin
      if (w.st.in_term) begin
        w = finish_term(w);
      end
      w.st = '0;
    end

    if (w.res.cnt != '0) begin
      last_idx = w.res.cnt[sqt_pkg::RES_IDX_W-1:0] - 1'b1;
      w.res.items[last_idx].last_of_run = 1'b1;
    end

    state_nxt = w.st;
    push      = w.res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/sqt_outq.sv */
module sqt_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_en,
  input  sqt_pkg::push_t                push,
  input  logic                          pop,
  output logic                          q_valid,
  output sqt_pkg::res_t                 q_head,
  output logic                          q_room,
  output logic [sqt_pkg::Q_CNT_W-1:0]   q_level
);

  sqt_pkg::res_t                 mem [sqt_pkg::Q_DEPTH];
  logic [sqt_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [sqt_pkg::Q_PTR_W-1:0]   wr_ptr_nxt;
  logic [sqt_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [sqt_pkg::Q_PTR_W-1:0]   rd_ptr_nxt;
  logic [sqt_pkg::Q_CNT_W-1:0]   level_r;
  logic [sqt_pkg::Q_CNT_W-1:0]   level_nxt;
  logic [sqt_pkg::RES_CNT_W-1:0] wr_cnt;

  assign wr_cnt  = push_en ? push.cnt : '0;
  assign q_valid = (level_r != '0);
  assign q_head  = mem[rd_ptr_r];
  // Room for a worst-case burst, judged from the registered fill level.
  assign q_room  = (level_r <= sqt_pkg::Q_CNT_W'(sqt_pkg::Q_DEPTH - sqt_pkg::MAX_RES));
  assign q_level = level_r;

  assign wr_ptr_nxt = wr_ptr_r + sqt_pkg::Q_PTR_W'(wr_cnt);
  assign rd_ptr_nxt = rd_ptr_r + sqt_pkg::Q_PTR_W'(pop);
  assign level_nxt  = level_r + sqt_pkg::Q_CNT_W'(wr_cnt) - sqt_pkg::Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < sqt_pkg::MAX_RES; k++) begin
      if (sqt_pkg::RES_CNT_W'(k) < wr_cnt) begin
        mem[wr_ptr_r + sqt_pkg::Q_PTR_W'(k)] <= push.items[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

/* rtl/search_query_tokenizer.sv */
// Channel | Direction | Handshake        | Payload
// in_     | input     | tvalid / tready  | tdata = byte_value, tlast = end_of_query
// out_    | output    | tvalid / tready  | tdata = term byte + flags, tuser = item_kind,
//         |           |                  | tlast = last_of_run
//
// One query byte is taken per cycle. An accepted item sits in the input
// register until the queue has room; there the tokenizer logic turns it into zero to four
// result items and pushes them all at once into an eight-entry result queue.
// The first result is offered on out_ once its item has passed the input register
// and has been written into the result queue.
// rst_n is synchronous and active low; it clears the tokenizer state and the queue.
// The input register moves on only while the queue has room for four more
// items, so a slow consumer stalls in_tready; otherwise the rate is one item
// per cycle, set by the combinational tokenizer step.
module search_query_tokenizer (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // end_of_query

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] term_byte, [8] term_negated,
                                  // [9] first_of_term, [10] highlight_term, [15:11] zero
  output logic [0:0]  out_tuser,  // [0] item_kind
  output logic        out_tlast   // last_of_run
);

  logic                        in_valid_r;
  logic                        in_valid_nxt;
  logic [7:0]                  in_byte_r;
  logic                        in_last_r;
  logic                        in_take;
  logic                        fire;
  logic                        pop;
  logic                        q_room;
  logic [sqt_pkg::Q_CNT_W-1:0] q_level;
  sqt_pkg::push_t              push;
  sqt_pkg::res_t               q_head;

  // The held item is tokenized in the cycle the queue can take its burst.
  assign fire      = in_valid_r && q_room;
  assign in_tready = !in_valid_r || fire;
  assign in_take   = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  sqt_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .byte_value   (in_byte_r),
    .end_of_query (in_last_r),
    .push         (push)
  );

  sqt_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_en (fire),
    .push    (push),
    .pop     (pop),
    .q_valid (out_tvalid),
    .q_head  (q_head),
    .q_room  (q_room),
    .q_level (q_level)
  );

  assign out_tdata = {5'b0, q_head.highlight_term, q_head.first_of_term,
                      q_head.term_negated, q_head.term_byte};
  assign out_tuser = q_head.item_kind;
  assign out_tlast = q_head.last_of_run;

  // The queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= sqt_pkg::Q_CNT_W'(sqt_pkg::Q_DEPTH))
    else $error("result queue overfilled");

  // Nothing follows a term-end within one input byte's results.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] == sqt_pkg::KIND_END) |-> out_tlast)
    else $error("term-end item not last of its run");

  // A term-end item carries no byte and no first-of-term mark.
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] == sqt_pkg::KIND_END)
      |-> (out_tdata[7:0] == 8'h00 && !out_tdata[9]))
    else $error("term-end item carries byte data");

  // A new item is only tokenized when the queue had room for a full burst.
  a_room_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (q_level <= sqt_pkg::Q_CNT_W'(sqt_pkg::Q_DEPTH)))
    else $error("burst pushed without room");

endmodule
